[design/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/elln_pkg.sv]
`timescale 1ns / 1ps
package elln_pkg;
    localparam int EMBED_DIM   = 16;
    localparam int VOCAB_DEPTH = 1024;
    localparam int DIM_W       = $clog2(EMBED_DIM);
    localparam int ID_W        = $clog2(VOCAB_DEPTH);
    localparam int ADDR_W      = ID_W + DIM_W;
    localparam int CNT_W       = DIM_W + 1;
    localparam int SUM_W       = 32 + DIM_W;
    localparam int ROOT_W      = (SUM_W + 1) / 2;
    localparam int ROOT_STEPS  = ROOT_W;
    localparam int NUM_W       = 29;
    localparam int QUO_W       = NUM_W + 1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] REG_ENTRIES   = 2'd0;
    localparam logic [1:0] REG_NORMALIZE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_ROOT,
        ST_EMIT_RD,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_sum;
        logic acc_sum;
        logic root_start;
        logic root_step;
        logic div_start;
        logic div_step;
        logic load_out;
        logic [DIM_W-1:0] rd_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic root_zero;
        logic div_done;
        logic root_done;
    } ctrl_stat_t;
endpackage

[design/embedding_lookup_l2_normalize.sv]
`timescale 1ns / 1ps
// Embedding table lookup with optional L2 normalization.
// Input channel (in_valid/in_stall): cmd=0 writes one Q4.12 element at
// (entry_id, element_index); cmd=1 looks up a vector.
// A lookup yields 16 transfers on the output channel (out_valid/out_stall),
// out_index 0..15, last on the final one, id_valid cleared with zero values
// when entry_id >= entries_in_use.
// Without normalization each element is read from the table in EMIT_RD and
// loaded into the output register in OUT.
// With normalization: a sum of squares in SUM, a restoring square root in
// ROOT, then per element a 30-step restoring divide (DIV_INIT, DIV) between
// EMIT_RD and OUT.
// in_stall is high while a lookup is in progress. Config port (cfg_we,
// cfg_index, cfg_data) writes registers; the user must write them only while
// idle, the block does not enforce it. Reset clears control and registers;
// table contents are undefined until written. When out_stall is high a full
// output register holds its transfer and the controller waits in EMIT_RD.
module embedding_lookup_l2_normalize
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [10:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic cmd,
    input  logic [9:0] entry_id,
    input  logic [3:0] element_index,
    input  logic signed [15:0] element_value,
    output logic out_valid,
    input  logic out_stall,
    output logic [3:0] out_index,
    output logic signed [15:0] out_value,
    output logic id_valid,
    output logic last
);
    logic [10:0] entries_reg;
    logic norm_en_reg;
    logic busy;
    logic norm_active;
    logic out_full;
    logic accept;
    logic start;
    logic wr_en;
    elln_pkg::ctrl_cmd_t ccmd;
    elln_pkg::ctrl_stat_t cstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
            norm_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == elln_pkg::REG_ENTRIES[0])
                entries_reg <= cfg_data;
            else
                norm_en_reg <= cfg_data[0];
        end
    end

    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;
    assign start    = accept && (cmd == elln_pkg::CMD_LOOKUP);
    assign wr_en    = accept && (cmd == elln_pkg::CMD_WRITE);

    logic id_ok;
    assign id_ok = ({1'b0, entry_id} < entries_reg);

    elln_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .do_norm(norm_en_reg && id_ok),
        .out_stall(out_stall),
        .out_full(out_full),
        .stat(cstat),
        .cmd(ccmd),
        .busy(busy),
        .norm_active(norm_active)
    );

    elln_datapath u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_addr({entry_id, element_index}),
        .wr_data(element_value),
        .start(start),
        .start_id(entry_id),
        .start_valid(id_ok),
        .norm_active(norm_active),
        .cmd(ccmd),
        .out_stall(out_stall),
        .stat(cstat),
        .out_full(out_full),
        .out_valid(out_valid),
        .out_index(out_index),
        .out_value(out_value),
        .id_valid(id_valid),
        .last(last)
    );
endmodule

[design/elln_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module elln_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic do_norm,
    input  logic out_stall,
    input  logic out_full,
    input  elln_pkg::ctrl_stat_t stat,
    output elln_pkg::ctrl_cmd_t cmd,
    output logic busy,
    output logic norm_active
);
    elln_pkg::state_t state_reg, state_next;
    logic [elln_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic norm_reg, norm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elln_pkg::ST_IDLE;
            cnt_reg   <= '0;
            norm_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            norm_reg  <= norm_next;
        end
    end

    assign busy        = (state_reg != elln_pkg::ST_IDLE);
    assign norm_active = norm_reg;

    // SUM: read cycle i then accumulate i-1; cnt runs 0..EMBED_DIM
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        norm_next  = norm_reg;
        cmd        = '0;
        cmd.rd_idx = cnt_reg[elln_pkg::DIM_W-1:0];
        unique case (state_reg)
            elln_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    norm_next     = do_norm;
                    cmd.clear_sum = 1'b1;
                    state_next    = do_norm ? elln_pkg::ST_SUM : elln_pkg::ST_EMIT_RD;
                end
            end
            elln_pkg::ST_SUM:
            begin
                cmd.acc_sum = (cnt_reg != '0);
                if (cnt_reg == elln_pkg::CNT_W'(elln_pkg::EMBED_DIM))
                begin
                    cnt_next       = '0;
                    cmd.root_start = 1'b1;
                    state_next     = elln_pkg::ST_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            elln_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_done)
                begin
                    cmd.root_step = 1'b0;
                    if (stat.root_zero)
                        norm_next = 1'b0;
                    state_next = elln_pkg::ST_EMIT_RD;
                end
            end
            elln_pkg::ST_EMIT_RD:
            begin
                if (!out_full)
                begin
                    if (norm_reg)
                        state_next = elln_pkg::ST_DIV_INIT;
                    else
                        state_next = elln_pkg::ST_OUT;
                end
            end
            // element read in EMIT_RD is now in the read register
            elln_pkg::ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = elln_pkg::ST_DIV;
            end
            elln_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next   = elln_pkg::ST_OUT;
                end
            end
            elln_pkg::ST_OUT:
            begin
                cmd.load_out = 1'b1;
                if (cnt_reg == elln_pkg::CNT_W'(elln_pkg::EMBED_DIM - 1))
                begin
                    cnt_next   = '0;
                    state_next = elln_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = elln_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = elln_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_start_idle, clk, rst_n, start, state_reg == elln_pkg::ST_IDLE)
    `ASSERT_IMPL(a_load_room, clk, rst_n, cmd.load_out, !out_full || !out_stall)
    `ASSERT_IMPL(a_cnt_range, clk, rst_n, busy, cnt_reg <= elln_pkg::CNT_W'(elln_pkg::EMBED_DIM))
endmodule

[design/elln_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module elln_datapath
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic [elln_pkg::ADDR_W-1:0] wr_addr,
    input  logic [15:0] wr_data,
    input  logic start,
    input  logic [elln_pkg::ID_W-1:0] start_id,
    input  logic start_valid,
    input  logic norm_active,
    input  elln_pkg::ctrl_cmd_t cmd,
    input  logic out_stall,
    output elln_pkg::ctrl_stat_t stat,
    output logic out_full,
    output logic out_valid,
    output logic [elln_pkg::DIM_W-1:0] out_index,
    output logic signed [15:0] out_value,
    output logic id_valid,
    output logic last
);
    logic signed [15:0] mem [0:elln_pkg::VOCAB_DEPTH*elln_pkg::EMBED_DIM-1];
    logic signed [15:0] rd_data_reg;
    logic [elln_pkg::ID_W-1:0] id_reg;
    logic vld_reg;
    logic [elln_pkg::SUM_W-1:0] sum_reg;
    logic [elln_pkg::SUM_W-1:0] rem_reg;
    logic [elln_pkg::ROOT_W-1:0] root_reg;
    logic [5:0] rstep_reg;
    logic [elln_pkg::QUO_W-1:0] quo_reg;
    logic [elln_pkg::ROOT_W+1:0] drem_reg;
    logic [elln_pkg::NUM_W:0] dnum_reg;
    logic [5:0] dstep_reg;
    logic dneg_reg;
    logic obuf_full_reg;
    logic [elln_pkg::DIM_W-1:0] oidx_reg;
    logic signed [15:0] oval_reg;
    logic ovld_reg;
    logic olast_reg;

    // table read every cycle at the index the controller presents
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[{id_reg, cmd.rd_idx}];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            id_reg  <= start_id;
            vld_reg <= start_valid;
        end
    end

    logic signed [31:0] sx;
    logic [31:0] sq;
    logic [elln_pkg::SUM_W-1:0] sum_acc;
    assign sx      = 32'(rd_data_reg);
    assign sq      = 32'(sx * sx);
    assign sum_acc = sum_reg + elln_pkg::SUM_W'(sq);

    always_ff @(posedge clk)
    begin
        if (cmd.clear_sum)
            sum_reg <= '0;
        else if (cmd.acc_sum)
            sum_reg <= sum_acc;
    end

    // restoring square root, two radicand bits per step
    logic [elln_pkg::ROOT_W+1:0] trial;
    logic [elln_pkg::ROOT_W+1:0] rpart;
    assign rpart = {root_reg[elln_pkg::ROOT_W-1:0], 2'b01};
    logic [elln_pkg::ROOT_W+1:0] rtop;
    logic [elln_pkg::SUM_W-1:0] rbits_reg;
    assign rtop  = {rem_reg[elln_pkg::ROOT_W-1:0], rbits_reg[elln_pkg::SUM_W-1 -: 2]};
    assign trial = rtop - rpart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rstep_reg <= '0;
        else if (cmd.root_start)
            rstep_reg <= 6'(elln_pkg::ROOT_STEPS);
        else if (cmd.root_step && rstep_reg != '0)
            rstep_reg <= rstep_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            rem_reg   <= '0;
            root_reg  <= '0;
            rbits_reg <= cmd.acc_sum ? sum_acc : sum_reg;
        end
        else if (cmd.root_step && rstep_reg != '0)
        begin
            rbits_reg <= rbits_reg << 2;
            if (rtop >= rpart)
            begin
                rem_reg  <= elln_pkg::SUM_W'(trial);
                root_reg <= {root_reg[elln_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= elln_pkg::SUM_W'(rtop);
                root_reg <= {root_reg[elln_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign stat.root_done = (rstep_reg == '0) && !cmd.root_start;
    assign stat.root_zero = (root_reg == '0);

    // restoring divider: (2*|x|*4096 + n) / (2n)
    logic [15:0] mag;
    assign mag = rd_data_reg[15] ? 16'(-rd_data_reg) : rd_data_reg;
    logic [elln_pkg::ROOT_W+1:0] dsh;
    logic [elln_pkg::ROOT_W+1:0] den;
    assign den = {1'b0, root_reg, 1'b0};
    assign dsh = {drem_reg[elln_pkg::ROOT_W:0], dnum_reg[elln_pkg::NUM_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dstep_reg <= '0;
        else if (cmd.div_start)
            dstep_reg <= 6'(elln_pkg::NUM_W + 1);
        else if (cmd.div_step && dstep_reg != '0)
            dstep_reg <= dstep_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dnum_reg <= (elln_pkg::NUM_W+1)'({mag, 13'b0}) +
                        (elln_pkg::NUM_W+1)'(root_reg);
            drem_reg <= '0;
            quo_reg  <= '0;
            dneg_reg <= rd_data_reg[15];
        end
        else if (cmd.div_step && dstep_reg != '0)
        begin
            dnum_reg <= dnum_reg << 1;
            if (dsh >= den)
            begin
                drem_reg <= dsh - den;
                quo_reg  <= {quo_reg[elln_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dsh;
                quo_reg  <= {quo_reg[elln_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = (dstep_reg == '0) && !cmd.div_start;

    logic signed [15:0] scaled;
    always_comb
    begin
        if (dneg_reg)
            scaled = (quo_reg > elln_pkg::QUO_W'(32768)) ? 16'sh8000 : 16'(-quo_reg);
        else
            scaled = (quo_reg > elln_pkg::QUO_W'(32767)) ? 16'sh7FFF : 16'(quo_reg);
    end

    logic signed [15:0] result;
    assign result = !vld_reg ? 16'sd0 : (norm_active ? scaled : rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            obuf_full_reg <= 1'b0;
        else if (cmd.load_out)
            obuf_full_reg <= 1'b1;
        else if (!out_stall)
            obuf_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            oidx_reg  <= cmd.rd_idx;
            oval_reg  <= result;
            ovld_reg  <= vld_reg;
            olast_reg <= (cmd.rd_idx == elln_pkg::DIM_W'(elln_pkg::EMBED_DIM - 1));
        end
    end

    assign out_full  = obuf_full_reg && out_stall;
    assign out_valid = obuf_full_reg;
    assign out_index = oidx_reg;
    assign out_value = oval_reg;
    assign id_valid  = ovld_reg;
    assign last      = olast_reg;

    `ASSERT_NEXT(a_load_sets_full, clk, rst_n, cmd.load_out, obuf_full_reg)
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, cmd.root_step, !cmd.div_step)
    `ASSERT_IMPL(a_hold, clk, rst_n, obuf_full_reg && out_stall, !cmd.load_out)
endmodule

[tb/embedding_lookup_l2_normalize_test.sv]
`timescale 1ns / 1ps
module embedding_lookup_l2_normalize_test;
    typedef struct packed {
        logic [3:0]         index;
        logic signed [15:0] value;
        logic               valid;
        logic               last;
    } element_t;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [10:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic cmd;
    logic [9:0] entry_id;
    logic [3:0] element_index;
    logic signed [15:0] element_value;
    logic out_valid;
    logic out_stall;
    logic [3:0] out_index;
    logic signed [15:0] out_value;
    logic id_valid;
    logic last;

    embedding_lookup_l2_normalize DUT (.*);

    logic signed [15:0] table_copy [elln_pkg::VOCAB_DEPTH][elln_pkg::EMBED_DIM];
    bit                 entry_written [elln_pkg::VOCAB_DEPTH];
    int unsigned        entries_cfg;
    bit                 normalize_cfg;
    element_t           pending_elements [$];
    int                 error_count;
    int                 idle_cycles;
    bit                 stall_enable;
    bit                 gap_enable;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] scaled(input int x, input logic [63:0] norm);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (x < 0) ? -x : x;
        q = (2 * (mag << 12) + norm) / (2 * norm);
        if (x < 0)
            return (q > 32768) ? 16'sh8000 : 16'(-q);
        return (q > 32767) ? 16'sh7FFF : 16'(q);
    endfunction

    task automatic predict_lookup(input logic [9:0] id);
        int          vec [elln_pkg::EMBED_DIM];
        bit          ok;
        logic [63:0] sum;
        logic [63:0] norm;
        element_t    e;
        ok = (id < entries_cfg) && (id < elln_pkg::VOCAB_DEPTH);
        sum = 0;
        for (int i = 0; i < elln_pkg::EMBED_DIM; i++)
        begin
            vec[i] = ok ? int'(table_copy[id][i]) : 0;
            sum += longint'(vec[i]) * longint'(vec[i]);
        end
        if (ok && normalize_cfg)
        begin
            norm = root_of(sum);
            if (norm != 0)
                for (int i = 0; i < elln_pkg::EMBED_DIM; i++)
                    vec[i] = scaled(vec[i], norm);
        end
        for (int i = 0; i < elln_pkg::EMBED_DIM; i++)
        begin
            e.index = i[3:0];
            e.value = vec[i][15:0];
            e.valid = ok;
            e.last = (i == elln_pkg::EMBED_DIM - 1);
            pending_elements.insert(pending_elements.size(), e);
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == elln_pkg::REG_ENTRIES[0])
            entries_cfg = (val > elln_pkg::VOCAB_DEPTH) ? elln_pkg::VOCAB_DEPTH : val;
        else
            normalize_cfg = val[0];
    endtask

    task automatic drain;
        while (pending_elements.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic send_item(input logic c, input logic [9:0] id,
                             input logic [3:0] ei, input logic [15:0] ev);
        if (gap_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        in_valid = 1'b1;
        cmd = c;
        entry_id = id;
        element_index = ei;
        element_value = ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == elln_pkg::CMD_WRITE)
        begin
            table_copy[id][ei] = ev;
            entry_written[id] = 1'b1;
        end
        else
            predict_lookup(id);
        @(negedge clk);
        in_valid = 1'b0;
        cmd = 1'($urandom);
        entry_id = 10'($urandom);
        element_index = 4'($urandom);
        element_value = 16'($urandom);
    endtask

    task automatic fill_entry(input logic [9:0] id, input int mode);
        logic [15:0] v;
        for (int i = 0; i < elln_pkg::EMBED_DIM; i++)
        begin
            case (mode)
                0: v = 16'h0000;
                1: v = 16'h7FFF;
                2: v = 16'h8000;
                3: v = (i == 0) ? 16'h0001 : 16'h0000;
                default: v = 16'($urandom);
            endcase
            send_item(elln_pkg::CMD_WRITE, id, i[3:0], v);
        end
    endtask

    task automatic test_directed;
        write_reg(elln_pkg::REG_ENTRIES[0], 11'd1024);
        write_reg(elln_pkg::REG_NORMALIZE[0], 11'd0);
        fill_entry(10'd0, 1);
        fill_entry(10'd1023, 2);
        fill_entry(10'd5, 0);
        fill_entry(10'd6, 3);
        fill_entry(10'd7, 4);
        send_item(elln_pkg::CMD_LOOKUP, 10'd0, 4'hF, 16'hFFFF);
        send_item(elln_pkg::CMD_LOOKUP, 10'd1023, 4'h0, 16'h0000);
        drain();
        write_reg(elln_pkg::REG_NORMALIZE[0], 11'd1);
        send_item(elln_pkg::CMD_LOOKUP, 10'd0, 4'h0, 16'h0);
        send_item(elln_pkg::CMD_LOOKUP, 10'd1023, 4'h0, 16'h0);
        send_item(elln_pkg::CMD_LOOKUP, 10'd5, 4'h0, 16'h0);
        send_item(elln_pkg::CMD_LOOKUP, 10'd6, 4'h0, 16'h0);
        send_item(elln_pkg::CMD_LOOKUP, 10'd7, 4'h0, 16'h0);
        drain();
        write_reg(elln_pkg::REG_ENTRIES[0], 11'd0);
        send_item(elln_pkg::CMD_LOOKUP, 10'd0, 4'h0, 16'h0);
        drain();
        write_reg(elln_pkg::REG_ENTRIES[0], 11'h7FF);
        send_item(elln_pkg::CMD_LOOKUP, 10'd1023, 4'h0, 16'h0);
        drain();
        write_reg(elln_pkg::REG_ENTRIES[0], 11'd8);
        send_item(elln_pkg::CMD_LOOKUP, 10'd7, 4'h0, 16'h0);
        send_item(elln_pkg::CMD_LOOKUP, 10'd8, 4'h0, 16'h0);
        drain();
    endtask

    // lookups hit fully written entries or invalid ids; writes update written entries
    task automatic test_random(input int count, input logic [10:0] entries,
                               input bit norm);
        int id;
        int hi;
        write_reg(elln_pkg::REG_ENTRIES[0], entries);
        write_reg(elln_pkg::REG_NORMALIZE[0], {10'd0, norm});
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                hi = ($urandom_range(0, 1) == 0) ? 7 : elln_pkg::VOCAB_DEPTH - 1;
                do
                    id = $urandom_range(0, hi);
                while (id < entries_cfg && !entry_written[id]);
                send_item(elln_pkg::CMD_LOOKUP, id[9:0], 4'($urandom), 16'($urandom));
            end
            else
            begin
                do
                    id = $urandom_range(0, 7);
                while (!entry_written[id]);
                send_item(elln_pkg::CMD_WRITE, id[9:0], 4'($urandom), 16'($urandom));
            end
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        element_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_elements.size() == 0)
            begin
                $display("%0t: unexpected transfer index=%0d value=%0d", $time,
                         out_index, out_value);
                error_count++;
            end
            else
            begin
                e = pending_elements.pop_front();
                if (out_index !== e.index || out_value !== e.value ||
                    id_valid !== e.valid || last !== e.last)
                begin
                    $display("%0t: expected idx=%0d val=%0d ok=%0d last=%0d, got idx=%0d val=%0d ok=%0d last=%0d",
                             $time, e.index, e.value, e.valid, e.last,
                             out_index, out_value, id_valid, last);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_enable && !out_stall && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 11'd0;
        in_valid = 1'b0;
        cmd = 1'b0;
        entry_id = 10'd0;
        element_index = 4'd0;
        element_value = 16'd0;
        out_stall = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        entries_cfg = 0;
        normalize_cfg = 1'b0;
        stall_enable = 1'b1;
        gap_enable = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(40, 11'd24, 1'b0);
        test_random(40, 11'd16, 1'b1);
        stall_enable = 1'b0;
        gap_enable = 1'b0;
        test_random(40, 11'd1024, 1'b1);
        drain();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
